@@ rtl/heap_sort_engine_unit_defines.svh @@
// ----------------------------------------------------------------------------
// heap sort engine assertion macros
// shared concurrent assertion helpers, clocked on clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef HEAP_SORT_ENGINE_UNIT_DEFINES_SVH
`define HEAP_SORT_ENGINE_UNIT_DEFINES_SVH

// implication checked in the same cycle
`define HSE_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// implication checked in the next cycle
`define HSE_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ rtl/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// heap sort engine package
// default sizes, field widths and sequencer states
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hse_pkg;

	localparam int DEF_MAX_ELEMENTS = 64;
	localparam int DEF_VALUE_WIDTH  = 32;
	localparam int FIELD_WIDTH      = 32;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_START,
		ST_BRD,
		ST_BLD,
		ST_SRD,
		ST_SCMP,
		ST_XRD,
		ST_XSW,
		ST_ERD,
		ST_EOUT
	} hse_state_t;

endpackage

@@ rtl/heap_sort_engine_unit.sv @@
// ----------------------------------------------------------------------------
// heap sort engine
// collects a set of signed values and returns them in ascending order
// ----------------------------------------------------------------------------
// usage
//   input stream s_*: one value per item in s_tdata, s_tlast marks the end of
//   a set. up to MAX_ELEMENTS values are kept, later ones are dropped and the
//   overflow flag goes out in m_tuser on every result of that set.
//   output stream m_*: the set in ascending order, m_tlast on the final item.
// timing
//   loading takes one item per cycle. after the last item the block builds a
//   max-heap and extracts it; each sift level reads the children from the
//   store's two read ports, then does one compare and write. a set of n
//   values needs about n/2 + n - 1 sifts of up to log2(n) levels, and the
//   store has a single write port. each result is emitted by a registered
//   read, then the output register. s_tready is low from the last item
//   until the final result is loaded.
// reset
//   arst_n clears the sequencer, the element count and the output valid.
//   the store is not cleared: only entries written in the current set are
//   read.
// stall
//   a stalled receiver holds the output register; emission waits, and once
//   the final result is loaded the next set may already be loading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heap_sort_engine_unit_defines.svh"

module heap_sort_engine_unit #(
	parameter int MAX_ELEMENTS = hse_pkg::DEF_MAX_ELEMENTS,
	parameter int VALUE_WIDTH  = hse_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [hse_pkg::FIELD_WIDTH-1:0] s_tdata,  // [31:0] value
	input  logic                          s_tlast,  // is_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [hse_pkg::FIELD_WIDTH-1:0] m_tdata,  // [31:0] sorted_value
	output logic                          m_tlast,  // last_out
	output logic                          m_tuser   // [0] overflow
);

	import hse_pkg::*;

	// widths of counts (0..MAX), indexes (0..MAX-1) and child indexes
	localparam int CW  = $clog2(MAX_ELEMENTS + 1);
	localparam int IW  = $clog2(MAX_ELEMENTS);
	localparam int CHW = $clog2(2 * MAX_ELEMENTS + 1);

	hse_state_t state_q, state_n;

	logic [CW-1:0]          count_q, count_n;  // elements held, also n during sort
	logic                   ovf_q, ovf_n;
	logic [CW-1:0]          k_q, k_n;          // outer loop counter of build / extract
	logic [CW-1:0]          size_q, size_n;    // heap size of the running sift
	logic [IW-1:0]          node_q, node_n;    // hole position of the running sift
	logic [VALUE_WIDTH-1:0] v_q, v_n;          // value being sifted down
	logic                   build_q, build_n;  // 1 while building the heap
	logic [IW-1:0]          ep_q, ep_n;        // emission pointer

	// output register
	logic                   m_tvalid_q;
	logic [FIELD_WIDTH-1:0] m_tdata_q;
	logic                   m_tlast_q;
	logic                   m_tuser_q;
	logic                   out_load;
	logic                   out_tlast_n;

	// element store, one write and two registered reads per cycle
	logic [VALUE_WIDTH-1:0] mem_q [MAX_ELEMENTS];
	logic                   we;
	logic [IW-1:0]          waddr;
	logic [VALUE_WIDTH-1:0] wdata;
	logic [IW-1:0]          raddr_a, raddr_b;
	logic [VALUE_WIDTH-1:0] rd_a_q, rd_b_q;

	logic [VALUE_WIDTH-1:0] in_val;
	logic [CHW-1:0]         left_w, right_w, size_w;
	logic                   s_acc;
	logic [CW-1:0]          k_dec;

	assign in_val  = VALUE_WIDTH'(s_tdata);
	assign left_w  = CHW'({node_q, 1'b0}) + CHW'(1);
	assign right_w = CHW'({node_q, 1'b0}) + CHW'(2);
	assign size_w  = CHW'(size_q);
	assign k_dec   = k_q - CW'(1);

	assign s_tready = (state_q == ST_LOAD);
	assign s_acc    = s_tvalid && s_tready;

	// store
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_a_q <= mem_q[raddr_a];
		rd_b_q <= mem_q[raddr_b];
	end

	// state and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			ovf_q   <= 1'b0;
			k_q     <= '0;
			size_q  <= '0;
			build_q <= 1'b0;
			ep_q    <= '0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			ovf_q   <= ovf_n;
			k_q     <= k_n;
			size_q  <= size_n;
			build_q <= build_n;
			ep_q    <= ep_n;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_n;
		v_q    <= v_n;
	end

	// sequencer
	always_comb begin
		logic take_l;
		logic take_r;
		logic sift_end;
		logic [VALUE_WIDTH-1:0] top_v;

		state_n  = state_q;
		count_n  = count_q;
		ovf_n    = ovf_q;
		k_n      = k_q;
		size_n   = size_q;
		node_n   = node_q;
		v_n      = v_q;
		build_n  = build_q;
		ep_n     = ep_q;
		we       = 1'b0;
		waddr    = node_q;
		wdata    = v_q;
		raddr_a  = ep_q;
		raddr_b  = ep_q;
		out_load = 1'b0;
		out_tlast_n = 1'b0;
		sift_end = 1'b0;
		take_l   = 1'b0;
		take_r   = 1'b0;
		top_v    = v_q;

		unique case (state_q)
			ST_LOAD: begin
				if (s_acc) begin
					if (count_q < CW'(MAX_ELEMENTS)) begin
						we      = 1'b1;
						waddr   = count_q[IW-1:0];
						wdata   = in_val;
						count_n = count_q + CW'(1);
					end else begin
						ovf_n = 1'b1;
					end
					if (s_tlast) begin
						state_n = ST_START;
					end
				end
			end
			ST_START: begin
				ep_n = '0;
				if (count_q > CW'(1)) begin
					k_n     = count_q >> 1;
					build_n = 1'b1;
					state_n = ST_BRD;
				end else begin
					state_n = ST_ERD;
				end
			end
			ST_BRD: begin
				raddr_a = k_dec[IW-1:0];
				state_n = ST_BLD;
			end
			ST_BLD: begin
				v_n     = rd_a_q;
				node_n  = k_dec[IW-1:0];
				size_n  = count_q;
				state_n = ST_SRD;
			end
			ST_SRD: begin
				if (left_w < size_w) begin
					raddr_a = left_w[IW-1:0];
					raddr_b = right_w[IW-1:0];
					state_n = ST_SCMP;
				end else begin
					// leaf: the hole takes the sifted value
					we       = 1'b1;
					sift_end = 1'b1;
				end
			end
			ST_SCMP: begin
				take_l = $signed(rd_a_q) > $signed(v_q);
				top_v  = take_l ? rd_a_q : v_q;
				take_r = (right_w < size_w) && ($signed(rd_b_q) > $signed(top_v));
				we     = 1'b1;
				if (take_r) begin
					wdata   = rd_b_q;
					node_n  = right_w[IW-1:0];
					state_n = ST_SRD;
				end else if (take_l) begin
					wdata   = rd_a_q;
					node_n  = left_w[IW-1:0];
					state_n = ST_SRD;
				end else begin
					sift_end = 1'b1;
				end
			end
			ST_XRD: begin
				raddr_a = '0;
				raddr_b = k_dec[IW-1:0];
				state_n = ST_XSW;
			end
			ST_XSW: begin
				// root goes to the end, old end value sifts from the root
				we      = 1'b1;
				waddr   = k_dec[IW-1:0];
				wdata   = rd_a_q;
				v_n     = rd_b_q;
				node_n  = '0;
				size_n  = k_dec;
				state_n = ST_SRD;
			end
			ST_ERD: begin
				raddr_a = ep_q;
				state_n = ST_EOUT;
			end
			ST_EOUT: begin
				raddr_a = ep_q;
				if (!m_tvalid_q || m_tready) begin
					out_load    = 1'b1;
					out_tlast_n = (CW'(ep_q) + CW'(1)) == count_q;
					if (out_tlast_n) begin
						count_n = '0;
						ovf_n   = 1'b0;
						state_n = ST_LOAD;
					end else begin
						ep_n    = ep_q + IW'(1);
						state_n = ST_ERD;
					end
				end
			end
			default: begin
				state_n = ST_LOAD;
			end
		endcase

		// next sift or move on to extraction / emission
		if (sift_end) begin
			ep_n = '0;
			if (build_q) begin
				if (k_q > CW'(1)) begin
					k_n     = k_dec;
					state_n = ST_BRD;
				end else begin
					build_n = 1'b0;
					k_n     = count_q;
					state_n = ST_XRD;
				end
			end else begin
				k_n     = k_dec;
				state_n = (k_dec > CW'(1)) ? ST_XRD : ST_ERD;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= FIELD_WIDTH'(rd_a_q);
			m_tlast_q <= out_tlast_n;
			m_tuser_q <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	// checks
	`HSE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CW'(MAX_ELEMENTS), "element count beyond store depth")
	`HSE_ASSERT_NOW(a_hole_in_heap, state_q == ST_SCMP, CW'(node_q) < size_q, "sift hole outside heap")
	`HSE_ASSERT_NOW(a_extract_range, state_q == ST_XSW, (k_q > CW'(1)) && (k_q <= count_q), "extract step out of range")
	`HSE_ASSERT_NOW(a_emit_range, state_q == ST_EOUT, CW'(ep_q) < count_q, "emission pointer past set")
	`HSE_ASSERT_NEXT(a_last_ends_set, out_load && out_tlast_n, (count_q == '0) && !ovf_q, "set state not cleared after final result")

endmodule

@@ tb/sv/tb_heap_sort_engine_unit.sv @@
// ----------------------------------------------------------------------------
// heap sort engine testbench
// feeds sets of signed values, predicts each sorted set and checks every
// result item field by field, under several sender and receiver idle mixes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_heap_sort_engine_unit;

	localparam int W        = hse_pkg::FIELD_WIDTH;
	localparam int MAX_HELD = hse_pkg::DEF_MAX_ELEMENTS;

	localparam logic signed [W-1:0] VAL_MAX = 32'sh7fff_ffff;
	localparam logic signed [W-1:0] VAL_MIN = 32'sh8000_0000;

	typedef struct {
		logic signed [W-1:0] value;
		bit                  last;
		bit                  dropped;
	} sorted_item_t;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [W-1:0]  s_tdata = '0;
	logic          s_tlast = 1'b0;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [W-1:0]  m_tdata;
	logic          m_tlast;
	logic          m_tuser;

	// predictor state: values held for the current set, drop flag
	logic signed [W-1:0] held_values[$];
	bit                  dropped_any;
	sorted_item_t        pending_sorted[$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int error_count    = 0;
	int items_sent     = 0;
	int results_seen   = 0;
	int sets_sorted    = 0;
	int overflow_sets  = 0;

	heap_sort_engine_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#(4_000_000);
		$display("timeout with %0d results still pending", pending_sorted.size());
		$display("DONE: errors detected");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
		$display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
		error_count++;
	endtask

	// ascending sort of a held set, then one result per value
	task automatic sort_held_set();
		logic signed [W-1:0] ordered[$];
		logic signed [W-1:0] key;
		sorted_item_t        r;
		int                  j;
		ordered = held_values;
		for (int i = 1; i < ordered.size(); i++) begin
			key = ordered[i];
			j = i - 1;
			while (j >= 0 && ordered[j] > key) begin
				ordered[j + 1] = ordered[j];
				j--;
			end
			ordered[j + 1] = key;
		end
		foreach (ordered[k]) begin
			r.value   = ordered[k];
			r.last    = (k == ordered.size() - 1);
			r.dropped = dropped_any;
			pending_sorted.push_back(r);
		end
		sets_sorted++;
		if (dropped_any)
			overflow_sets++;
		held_values.delete();
		dropped_any = 0;
	endtask

	// store full: the value is dropped, a last item included
	task automatic absorb_value(logic signed [W-1:0] v, bit last);
		if (held_values.size() < MAX_HELD)
			held_values.push_back(v);
		else
			dropped_any = 1;
		if (last)
			sort_held_set();
	endtask

	// called just after a rising edge; returns just after the accepting edge
	task automatic send_item(logic signed [W-1:0] v, bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		items_sent++;
		absorb_value(v, last);
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_sorted.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $signed($urandom_range(0, 8)) - 4;  // many equal values
			1: return VAL_MAX - $urandom_range(0, 2);
			2: return VAL_MIN + $urandom_range(0, 2);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_set(int count);
		for (int i = 0; i < count; i++)
			send_item(pick_value(), i == count - 1);
	endtask

	task automatic send_list(logic signed [W-1:0] vals[$]);
		foreach (vals[i])
			send_item(vals[i], i == vals.size() - 1);
	endtask

	// result checker: oldest expectation first
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_sorted.size() == 0) begin
				report_mismatch("result with nothing pending", m_tdata, '0);
			end else begin
				if (m_tdata !== pending_sorted[0].value)
					report_mismatch("sorted_value", m_tdata, pending_sorted[0].value);
				if (m_tlast !== pending_sorted[0].last)
					report_mismatch("last_out", m_tlast, pending_sorted[0].last);
				if (m_tuser !== pending_sorted[0].dropped)
					report_mismatch("overflow", m_tuser, pending_sorted[0].dropped);
				void'(pending_sorted.pop_front());
			end
		end
	end

	// a single value, extremes with duplicates, reverse order, all equal,
	// alternating bit patterns
	task automatic test_directed_sets();
		send_list('{VAL_MIN});
		send_list('{VAL_MAX, VAL_MIN, 0, -1, 1, VAL_MAX, VAL_MIN});
		send_list('{5, 4, 3, 2, 1});
		send_list('{7, 7, 7, 7});
		send_list('{32'sh5555_5555, 32'shaaaa_aaaa, 32'shffff_0000});
		stop_sending();
		wait_drained();
	endtask

	// exactly full store, then one and then two values past the limit
	task automatic test_store_limit();
		send_idle_pct  = 0;
		recv_stall_pct = 30;
		send_set(MAX_HELD);
		send_set(MAX_HELD + 1);
		stop_sending();
		wait_drained();
		send_set(MAX_HELD + 2);
		stop_sending();
		wait_drained();
	endtask

	// mostly small sets, one idle mix per phase; the sender waits for the
	// sorted output to drain at the end of every phase
	task automatic test_random_sets(int send_pct, int recv_pct, int budget);
		int sent;
		int size;
		int pick;
		sent = 0;
		send_idle_pct  = send_pct;
		recv_stall_pct = recv_pct;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 50)
				size = $urandom_range(1, 4);
			else if (pick < 90)
				size = $urandom_range(5, 16);
			else
				size = $urandom_range(17, 40);
			send_set(size);
			sent += size;
		end
		stop_sending();
		wait_drained();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sets();
		test_store_limit();
		test_random_sets(0, 0, 40);
		test_random_sets(75, 0, 40);
		test_random_sets(0, 75, 40);
		test_random_sets(18, 18, 40);
		recv_stall_pct = 0;
		wait_drained();
		repeat (200) @(posedge clk);
		$display("sent %0d values in %0d sets, checked %0d sorted results",
			items_sent, sets_sorted, results_seen);
		$display("%0d sets dropped values past the store limit", overflow_sets);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
